### design/hzb_pkg.sv
// ----------------------------------------------------------------------------
// hzb_pkg: shared constants and types
// Screen size, depth width and the token that moves between pyramid cells.
// ----------------------------------------------------------------------------
package hzb_pkg;

  localparam int SIDE_LOG2  = 6;
  localparam int DEPTH_BITS = 16;
  localparam int QUAD_W     = 4 * DEPTH_BITS;
  localparam int CLR_LEN    = 1 << (2 * (SIDE_LOG2 - 1));
  localparam int CLR_W      = 2 * (SIDE_LOG2 - 1) + 1;

  typedef logic [DEPTH_BITS-1:0] depth_t;

  // Updated node maximum handed from one level to the next
  typedef struct packed {
    logic   valid;
    depth_t val;
  } tok_t;

  function automatic depth_t max2(depth_t a, depth_t b);
    return (a > b) ? a : b;
  endfunction

endpackage

### design/hzb_ram.sv
// ----------------------------------------------------------------------------
// hzb_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module hzb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### design/hzb_cell.sv
// ----------------------------------------------------------------------------
// hzb_cell: one pyramid level
// Replaces one child of a quad, writes the quad back and hands the quad
// maximum to the next level up.
// ----------------------------------------------------------------------------
module hzb_cell import hzb_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  tok_t              tok_in,
  input  logic [QUAD_W-1:0] rdata,
  input  logic [1:0]        sel,
  output logic              we,
  output logic [QUAD_W-1:0] wdata,
  output tok_t              tok_out,
  output depth_t            child
);

  depth_t lane [4];
  depth_t nlane [4];
  depth_t qmax;

  // Split quad, pick the addressed child and splice in the new value
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      lane[i]  = rdata[i*DEPTH_BITS +: DEPTH_BITS];
      nlane[i] = (sel == 2'(i)) ? tok_in.val : lane[i];
    end
    child = lane[sel];
    qmax  = max2(max2(nlane[0], nlane[1]), max2(nlane[2], nlane[3]));
    wdata = {nlane[3], nlane[2], nlane[1], nlane[0]};
    we    = tok_in.valid;
  end

  // Advance the token to the next level
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out.valid <= tok_in.valid;
    end
    tok_out.val <= qmax;
  end

endmodule

### design/hierarchical_z_buffer_top.sv
// ----------------------------------------------------------------------------
// hierarchical_z_buffer_top: quadtree depth buffer
// A chain of level cells, each with a quad-wide RAM, plus a root register.
// ----------------------------------------------------------------------------
// Channel | Handshake          | Beat fields
// in      | in_valid/in_stall  | cmd px py depth color level
// out     | out_valid/out_stall| write_pixel out_x out_y out_color hidden node_max
//
// Each item runs as one RAM read of all levels, then the updated maximum climbs
// the cell chain level by level to the root; no new item is taken before it ends.
// After reset a clearing pass fills every level with far depth; no item is taken
// meanwhile. A finished result waits in the output register while the next item
// runs; a held result stalls the next one.
// ----------------------------------------------------------------------------
module hierarchical_z_buffer_top import hzb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        cmd,
  input  logic [5:0]  px,
  input  logic [5:0]  py,
  input  logic [15:0] depth,
  input  logic [23:0] color,
  input  logic [2:0]  level,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        write_pixel,
  output logic [5:0]  out_x,
  output logic [5:0]  out_y,
  output logic [23:0] out_color,
  output logic        hidden,
  output logic [15:0] node_max
);

  logic             in_acc;
  logic             busy;
  logic [2:0]       ph;
  logic             res_pend;
  logic [CLR_W-1:0] clr_cnt;
  logic             clearing;

  logic        cmd_q;
  logic [5:0]  x_q;
  logic [5:0]  y_q;
  depth_t      z_q;
  logic [23:0] color_q;
  logic [2:0]  lvl_q;
  depth_t      root;

  logic [QUAD_W-1:0] rdata [SIDE_LOG2];
  depth_t            child [SIDE_LOG2];
  tok_t              tok   [SIDE_LOG2+1];

  logic        r_wp;
  logic [5:0]  r_x;
  logic [5:0]  r_y;
  logic [23:0] r_color;
  logic        r_hid;
  depth_t      r_max;

  logic   decide;
  logic   pass;
  depth_t leaf;
  depth_t qm;

  assign clearing = (clr_cnt != CLR_W'(CLR_LEN));
  assign in_stall = busy | res_pend | clearing;
  assign in_acc   = in_valid & ~in_stall;
  assign decide   = busy & (ph == 3'd0);

  // Depth test on the leaf and query lookup
  always_comb begin
    leaf = child[0];
    pass = (cmd_q == 1'b0) && (z_q < leaf);
    if (lvl_q >= 3'(SIDE_LOG2)) begin
      qm = root;
    end else begin
      qm = child[lvl_q];
    end
    tok[0].valid = decide & pass;
    tok[0].val   = z_q;
  end

  // Level cells and their RAMs
  for (genvar k = 0; k < SIDE_LOG2; k++) begin : g_lvl
    localparam int DEP = 1 << (2 * (SIDE_LOG2 - 1 - k));
    localparam int AW  = (DEP > 1) ? $clog2(DEP) : 1;

    logic [2*SIDE_LOG2-1:0] idx;
    logic                   c_we;
    logic [QUAD_W-1:0]      c_wdata;
    logic                   m_we;
    logic [AW-1:0]          m_waddr;
    logic [QUAD_W-1:0]      m_wdata;
    logic [AW-1:0]          m_raddr;
    logic [AW-1:0]          rd_addr_q;

    assign idx = ({6'd0, py >> (k + 1)} << (SIDE_LOG2 - 1 - k))
               | {6'd0, px >> (k + 1)};
    assign m_raddr = idx[AW-1:0];

    // Clearing pass owns the write port after reset
    always_comb begin
      if (clearing) begin
        m_we    = (clr_cnt < CLR_W'(DEP));
        m_waddr = clr_cnt[AW-1:0];
        m_wdata = {QUAD_W{1'b1}};
      end else begin
        m_we    = c_we;
        m_waddr = rd_addr_q;
        m_wdata = c_wdata;
      end
    end

    // Hold the read address for write-back
    always_ff @(posedge clk) begin
      if (in_acc) begin
        rd_addr_q <= m_raddr;
      end
    end

    hzb_ram #(.WIDTH(QUAD_W), .DEPTH(DEP)) u_ram (
      .clk   (clk),
      .we    (m_we),
      .waddr (m_waddr),
      .wdata (m_wdata),
      .re    (in_acc),
      .raddr (m_raddr),
      .rdata (rdata[k])
    );

    hzb_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .tok_in  (tok[k]),
      .rdata   (rdata[k]),
      .sel     ({y_q[k], x_q[k]}),
      .we      (c_we),
      .wdata   (c_wdata),
      .tok_out (tok[k+1]),
      .child   (child[k])
    );
  end

  // Latch the accepted beat
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_q   <= cmd;
      x_q     <= px;
      y_q     <= py;
      z_q     <= depth;
      color_q <= color;
      lvl_q   <= level;
    end
  end

  // Sequence the item, clearing pass and root
  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      ph      <= 3'd0;
      clr_cnt <= '0;
      root    <= '1;
    end else begin
      if (clearing) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (in_acc) begin
        busy <= 1'b1;
        ph   <= 3'd0;
      end else if (busy) begin
        ph <= ph + 3'd1;
        if (ph == 3'(SIDE_LOG2)) begin
          busy <= 1'b0;
        end
      end
      if (tok[SIDE_LOG2].valid) begin
        root <= tok[SIDE_LOG2].val;
      end
    end
  end

  // Build the pending result, then move it to the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_pend  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (decide) begin
        res_pend <= 1'b1;
      end else if (res_pend && (!out_valid || !out_stall)) begin
        res_pend <= 1'b0;
      end
      if (res_pend && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
    if (decide) begin
      r_wp    <= pass;
      r_x     <= pass ? x_q : 6'd0;
      r_y     <= pass ? y_q : 6'd0;
      r_color <= pass ? color_q : 24'd0;
      r_hid   <= cmd_q & (qm <= z_q);
      r_max   <= cmd_q ? qm : (pass ? z_q : leaf);
    end
    if (res_pend && (!out_valid || !out_stall)) begin
      write_pixel <= r_wp;
      out_x       <= r_x;
      out_y       <= r_y;
      out_color   <= r_color;
      hidden      <= r_hid;
      node_max    <= r_max;
    end
  end

endmodule

### design/hzb_checker.sv
// ----------------------------------------------------------------------------
// hzb_checker: port-level checks
// Watches the top-level ports and flags inconsistent results.
// ----------------------------------------------------------------------------
module hzb_checker import hzb_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        write_pixel,
  input logic [5:0]  out_x,
  input logic [5:0]  out_y,
  input logic [23:0] out_color,
  input logic        hidden,
  input logic [15:0] node_max
);

  // A stalled result stays
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // A pixel write never reports hidden
  a_wp_hid: assert property (@(posedge clk) disable iff (rst)
    out_valid && write_pixel |-> !hidden)
    else $error("pixel write flagged hidden");

  // A passing depth is never the far value
  a_wp_far: assert property (@(posedge clk) disable iff (rst)
    out_valid && write_pixel |-> node_max != {DEPTH_BITS{1'b1}})
    else $error("far depth passed test");

  // No write means zeroed write fields
  a_nowp: assert property (@(posedge clk) disable iff (rst)
    out_valid && !write_pixel |-> out_x == 6'd0 && out_y == 6'd0 && out_color == 24'd0)
    else $error("write fields set without write");

  // An accepted beat keeps the block busy next cycle
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("accepted back to back");

endmodule

bind hierarchical_z_buffer_top hzb_checker u_hzb_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .write_pixel (write_pixel),
  .out_x       (out_x),
  .out_y       (out_y),
  .out_color   (out_color),
  .hidden      (hidden),
  .node_max    (node_max)
);

### test/hierarchical_z_buffer_top_tb.sv
// ----------------------------------------------------------------------------
// hierarchical_z_buffer_top_tb: depth test and occlusion query check
// Feeds pixel writes and node queries through the input channel with random
// gaps, mirrors the depth pyramid locally and compares every output beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module hierarchical_z_buffer_top_tb;
  import hzb_pkg::*;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_QUERY = 1'b1;
  localparam int   N_RANDOM  = 830;

  typedef struct packed {
    logic        cmd;
    logic [5:0]  px;
    logic [5:0]  py;
    logic [15:0] depth;
    logic [23:0] color;
    logic [2:0]  level;
  } zreq_t;

  typedef struct packed {
    logic        write_pixel;
    logic [5:0]  out_x;
    logic [5:0]  out_y;
    logic [23:0] out_color;
    logic        hidden;
    logic [15:0] node_max;
  } zres_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic cmd = 1'b0;
  logic [5:0] px = '0;
  logic [5:0] py = '0;
  logic [15:0] depth = '0;
  logic [23:0] color = '0;
  logic [2:0] level = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic write_pixel;
  logic [5:0] out_x;
  logic [5:0] out_y;
  logic [23:0] out_color;
  logic hidden;
  logic [15:0] node_max;

  zreq_t pending_q[$];
  zres_t expected_q[$];
  int    errors = 0;
  bit    hold_send = 1'b0;
  int    send_gap = 0;
  int    recv_gap = 0;

  // Local pyramid: per level a 64x64 array, only the low side>>lvl entries used
  depth_t pyr[0:SIDE_LOG2][0:63][0:63];

  hierarchical_z_buffer_top uut (.*);

  always #4 clk = ~clk;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Append one item to the stimulus queue
  task automatic queue_req(zreq_t r);
    pending_q = {pending_q, r};
  endtask

  // Compute the expected beat and update the pyramid
  function automatic zres_t zbuf_apply(zreq_t r);
    zres_t res;
    int lv;
    int cx;
    int cy;
    depth_t m;
    res = '0;
    if (r.cmd == CMD_PIXEL) begin
      if (r.depth < pyr[0][r.py][r.px]) begin
        pyr[0][r.py][r.px] = r.depth;
        for (lv = 1; lv <= SIDE_LOG2; lv++) begin
          cx = (r.px >> lv) << 1;
          cy = (r.py >> lv) << 1;
          m = pyr[lv-1][cy][cx];
          if (pyr[lv-1][cy][cx+1] > m) m = pyr[lv-1][cy][cx+1];
          if (pyr[lv-1][cy+1][cx] > m) m = pyr[lv-1][cy+1][cx];
          if (pyr[lv-1][cy+1][cx+1] > m) m = pyr[lv-1][cy+1][cx+1];
          pyr[lv][r.py >> lv][r.px >> lv] = m;
        end
        res.write_pixel = 1'b1;
        res.out_x = r.px;
        res.out_y = r.py;
        res.out_color = r.color;
      end
      res.node_max = pyr[0][r.py][r.px];
    end else begin
      lv = (r.level > SIDE_LOG2) ? SIDE_LOG2 : r.level;
      m = pyr[lv][r.py >> lv][r.px >> lv];
      res.hidden = (m <= r.depth);
      res.node_max = m;
    end
    return res;
  endfunction

  function automatic zreq_t mk_req(logic c, int x, int y, int d, int clr, int lv);
    zreq_t r;
    r.cmd = c;
    r.px = 6'(x);
    r.py = 6'(y);
    r.depth = 16'(d);
    r.color = 24'(clr);
    r.level = 3'(lv);
    return r;
  endfunction

  // Fill the stimulus queue
  initial begin
    zreq_t r;
    int i;
    int bx;
    int by;
    int k;
    int lv;
    for (i = 0; i <= SIDE_LOG2; i++)
      for (bx = 0; bx < 64; bx++)
        for (by = 0; by < 64; by++) pyr[i][by][bx] = '1;
    // Directed: queries on empty screen, far pixel, extremes, all levels
    queue_req(mk_req(CMD_QUERY, 0, 0, 16'hFFFF, 0, 6));
    queue_req(mk_req(CMD_QUERY, 63, 63, 16'hFFFE, 0, 7));
    queue_req(mk_req(CMD_PIXEL, 5, 9, 16'hFFFF, 24'hFFFFFF, 0));
    queue_req(mk_req(CMD_PIXEL, 0, 0, 16'h0000, 24'hFFFFFF, 7));
    queue_req(mk_req(CMD_PIXEL, 0, 0, 16'h0000, 24'h123456, 0));
    queue_req(mk_req(CMD_PIXEL, 63, 63, 16'h8000, 24'h000000, 0));
    queue_req(mk_req(CMD_PIXEL, 63, 63, 16'h7FFF, 24'hA5A5A5, 0));
    queue_req(mk_req(CMD_PIXEL, 1, 0, 16'h0010, 24'h5A5A5A, 0));
    queue_req(mk_req(CMD_PIXEL, 0, 1, 16'h0020, 24'h0F0F0F, 0));
    queue_req(mk_req(CMD_PIXEL, 1, 1, 16'h0030, 24'hF0F0F0, 0));
    for (lv = 0; lv < 8; lv++)
      queue_req(mk_req(CMD_QUERY, 0, 1, 16'h0030, 0, lv));
    queue_req(mk_req(CMD_QUERY, 63, 63, 16'hFFFF, 0, 0));
    queue_req(mk_req(CMD_QUERY, 63, 63, 16'h0000, 0, 0));
    // Random: groups of twelve items, mostly on one 4x4 block, mixing pixel writes and queries
    i = 0;
    while (i < N_RANDOM) begin
      bx = $urandom_range(0, 15) * 4;
      by = $urandom_range(0, 15) * 4;
      for (k = 0; k < 12 && i < N_RANDOM; k++) begin
        r.px = 6'(bx + $urandom_range(0, 3));
        r.py = 6'(by + $urandom_range(0, 3));
        r.color = 24'($urandom);
        r.level = 3'($urandom_range(0, 7));
        r.cmd = ($urandom_range(0, 3) == 0) ? CMD_QUERY : CMD_PIXEL;
        case ($urandom_range(0, 3))
          0: r.depth = 16'($urandom);
          1: r.depth = 16'($urandom_range(0, 255));
          2: r.depth = 16'(16'hFFFF - $urandom_range(0, 3));
          default: r.depth = 16'($urandom_range(0, 16'h3FFF));
        endcase
        if ($urandom_range(0, 7) == 0) begin
          r.px = 6'($urandom);
          r.py = 6'($urandom);
        end
        queue_req(r);
        i++;
      end
    end
  end

  // Reset, then pause once for a full drain mid-run, then finish
  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    wait (pending_q.size() < 400);
    hold_send = 1'b1;
    @(posedge clk);
    while (in_valid || expected_q.size() != 0) @(posedge clk);
    hold_send = 1'b0;
    wait (pending_q.size() == 0);
    @(posedge clk);
    while (in_valid || expected_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("hierarchical_z_buffer_top: match");
    end else begin
      $display("hierarchical_z_buffer_top: mismatch");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("hierarchical_z_buffer_top: mismatch");
    $finish;
  end

  // Driver: present a beat, hold it while stalled, advance on acceptance
  always @(posedge clk) begin
    zreq_t r;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        expected_q = {expected_q, zbuf_apply({cmd, px, py, depth, color, level})};
      end
      if (in_valid && in_stall) begin
        // hold
      end else if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_q.size() != 0 && !hold_send) begin
        r = pending_q.pop_front();
        {cmd, px, py, depth, color, level} <= r;
        in_valid <= 1'b1;
        send_gap <= gap_len();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: random stall on the output, compare each accepted beat
  always @(posedge clk) begin
    zres_t exp_res;
    zres_t got;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        got = {write_pixel, out_x, out_y, out_color, hidden, node_max};
        if (expected_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected beat %h", got);
        end else begin
          exp_res = expected_q.pop_front();
          if (got !== exp_res) begin
            errors++;
            if (errors <= 10) begin
              $display("beat differs: exp wp=%b x=%0d y=%0d c=%h h=%b m=%h",
                       exp_res.write_pixel, exp_res.out_x, exp_res.out_y,
                       exp_res.out_color, exp_res.hidden, exp_res.node_max);
              $display("              got wp=%b x=%0d y=%0d c=%h h=%b m=%h",
                       got.write_pixel, got.out_x, got.out_y, got.out_color,
                       got.hidden, got.node_max);
            end
          end
        end
      end
      if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_stall <= 1'b1;
      end else if ($urandom_range(0, 3) == 0) begin
        recv_gap <= gap_len();
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

endmodule
